@@ src/cbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_pkg
// Shared constants for the bilinear color lookup block.
// ----------------------------------------------------------------------------
package cbl_pkg;

	localparam int CMD_W = 2;
	localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_1D = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_2D = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_X_GAIN   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_GAIN   = 3'd5;

	localparam int PADDR_W  = 5;
	localparam int DIM_W    = 7;
	localparam int COORD_W  = 32;
	localparam int INDEX_W  = 12;
	localparam int CHAN_W   = 16;
	localparam int NCHAN    = 4;
	localparam int ENTRY_W  = CHAN_W * NCHAN;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 7'd1;
	localparam logic [COORD_W-1:0] GAIN_RST   = 32'h0001_0000;

	typedef logic [CHAN_W-1:0] chan_t;

endpackage

@@ src/cbl_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_if
// Request and response channels of the color lookup block.
// ----------------------------------------------------------------------------
interface cbl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [11:0] entry_index;
	logic [15:0] entry_red;
	logic [15:0] entry_green;
	logic [15:0] entry_blue;
	logic [15:0] entry_alpha;

	modport source (output valid, command, coord_x, coord_y, entry_index,
		entry_red, entry_green, entry_blue, entry_alpha, input ready);
	modport sink (input valid, command, coord_x, coord_y, entry_index,
		entry_red, entry_green, entry_blue, entry_alpha, output ready);
endinterface

interface cbl_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_red;
	logic [15:0] out_green;
	logic [15:0] out_blue;
	logic [15:0] out_alpha;

	modport source (output valid, out_red, out_green, out_blue, out_alpha,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha,
		output ready);
endinterface

@@ src/colormap_bilinear_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_bilinear_lookup
// RGBA color table with bilinear (or linear) interpolated lookups.
// ----------------------------------------------------------------------------
// channel  dir  handshake        contents
// req      in   valid/ready      command, coords, table entry to write
// rsp      out  valid/ready      interpolated RGBA, one per lookup
// apb      in   psel/penable     six config registers at 4*i
//
// One request per cycle unless the pipeline holds; a lookup passes s1..s6 and the output register.
// Table reads use two RAM copies with two read ports each (four neighbors).
// Writes and reads hit the RAMs in the same stage, so order is kept.
// The whole pipeline holds while a response waits and rsp.ready is low.
// Reset clears valid bits and sets config registers to their defaults; the table is undefined until written.
// ----------------------------------------------------------------------------
module colormap_bilinear_lookup
	import cbl_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	cbl_req_if.sink            req,
	cbl_rsp_if.source          rsp
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);

	// configuration
	logic [DIM_W-1:0]   width_q, height_q;
	logic [COORD_W-1:0] x_off_q, x_gain_q, y_off_q, y_gain_q;
	logic               cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			x_off_q  <= '0;
			x_gain_q <= GAIN_RST;
			y_off_q  <= '0;
			y_gain_q <= GAIN_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:    width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT:   height_q <= pwdata[DIM_W-1:0];
				REG_X_OFFSET: x_off_q  <= pwdata;
				REG_X_GAIN:   x_gain_q <= pwdata;
				REG_Y_OFFSET: y_off_q  <= pwdata;
				REG_Y_GAIN:   y_gain_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:    prdata = 32'(width_q);
			REG_HEIGHT:   prdata = 32'(height_q);
			REG_X_OFFSET: prdata = x_off_q;
			REG_X_GAIN:   prdata = x_gain_q;
			REG_Y_OFFSET: prdata = y_off_q;
			REG_Y_GAIN:   prdata = y_gain_q;
			default:      prdata = '0;
		endcase
	end

	// effective dimensions, clamped to 1..MAX
	logic [WW-1:0] w_eff, w_lim;
	logic [HW-1:0] h_eff, h_lim;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		w_lim = w_eff - WW'(1);
		h_lim = h_eff - HW'(1);
	end

	// pipeline control: everything moves together
	logic advance;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;

	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = advance;

	// s1: registered request
	logic [1:0]         cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [COORD_W-1:0] cx_s1, cy_s1;
	logic [INDEX_W-1:0] ei_s1, ei_s2, ei_s3, ei_s4;
	logic [ENTRY_W-1:0] ed_s1, ed_s2, ed_s3, ed_s4;

	// s2: offset removed
	logic [32:0]        dx, dy;
	logic [COORD_W-1:0] dx_s2, dy_s2;
	logic               px_s2, py_s2;

	// s3: scaled products
	logic [63:0] sx_s3, sy_s3;
	logic        px_s3, py_s3;

	// s4: indices and fractions
	logic [XW-1:0]     xi, x1;
	logic [YW-1:0]     yi, y1;
	logic [CHAN_W-1:0] xf, yf;
	logic [XW-1:0]     xi_s4, x1_s4;
	logic [YW-1:0]     yi_s4, y1_s4;
	logic [CHAN_W-1:0] xf_s4, yf_s4;

	// s5: table data
	logic [CHAN_W-1:0] xf_s5, yf_s5, yf_s6;
	logic [ENTRY_W-1:0] ll_s5, hl_s5, lh_s5, hh_s5;

	// s6: horizontal blends
	logic [NCHAN-1:0][31:0] top_s6, bot_s6;

	logic [NCHAN-1:0][CHAN_W-1:0] out_q;

	assign dx = {cx_s1[31], cx_s1} - {x_off_q[31], x_off_q};
	assign dy = {cy_s1[31], cy_s1} - {y_off_q[31], y_off_q};

	// index saturation: below offset gives 0, at or past the edge gives dim-1
	always_comb begin
		xi = '0;
		xf = '0;
		if (px_s3) begin
			if (sx_s3[63:32] >= 32'(w_lim)) begin
				xi = XW'(w_lim);
			end else begin
				xi = XW'(sx_s3[63:32]);
				xf = sx_s3[31:16];
			end
		end
		yi = '0;
		yf = '0;
		if (py_s3) begin
			if (sy_s3[63:32] >= 32'(h_lim)) begin
				yi = YW'(h_lim);
			end else begin
				yi = YW'(sy_s3[63:32]);
				yf = sy_s3[31:16];
			end
		end
		x1 = (32'(xi) == 32'(w_lim)) ? xi : xi + XW'(1);
		y1 = (32'(yi) == 32'(h_lim)) ? yi : yi + YW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (cmd_s4 == CMD_LOOKUP_1D || cmd_s4 == CMD_LOOKUP_2D);
			v_s6 <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1 <= req.command;
			cx_s1  <= req.coord_x;
			cy_s1  <= req.coord_y;
			ei_s1  <= req.entry_index;
			ed_s1  <= {req.entry_alpha, req.entry_blue, req.entry_green, req.entry_red};

			cmd_s2 <= cmd_s1;
			ei_s2  <= ei_s1;
			ed_s2  <= ed_s1;
			dx_s2  <= dx[31:0];
			dy_s2  <= dy[31:0];
			px_s2  <= !dx[32] && (dx != '0);
			py_s2  <= (cmd_s1 == CMD_LOOKUP_2D) && !dy[32] && (dy != '0);

			cmd_s3 <= cmd_s2;
			ei_s3  <= ei_s2;
			ed_s3  <= ed_s2;
			sx_s3  <= 64'(dx_s2) * 64'(x_gain_q);
			sy_s3  <= 64'(dy_s2) * 64'(y_gain_q);
			px_s3  <= px_s2;
			py_s3  <= py_s2;

			cmd_s4 <= cmd_s3;
			ei_s4  <= ei_s3;
			ed_s4  <= ed_s3;
			xi_s4  <= xi;
			x1_s4  <= x1;
			yi_s4  <= yi;
			y1_s4  <= y1;
			xf_s4  <= xf;
			yf_s4  <= yf;

			xf_s5  <= xf_s4;
			yf_s5  <= yf_s4;
			yf_s6  <= yf_s5;
		end
	end

	// s4: table access, writes and reads in the same stage
	logic [AW:0]        row0, row1, a_ll, a_hl, a_lh, a_hh;
	logic               ram_we;
	logic [ENTRY_W-1:0] rd_ll, rd_hl, rd_lh, rd_hh;

	assign row0 = (AW+1)'(yi_s4) * (AW+1)'(w_eff);
	assign row1 = (AW+1)'(y1_s4) * (AW+1)'(w_eff);
	assign a_ll = row0 + (AW+1)'(xi_s4);
	assign a_hl = row0 + (AW+1)'(x1_s4);
	assign a_lh = row1 + (AW+1)'(xi_s4);
	assign a_hh = row1 + (AW+1)'(x1_s4);
	assign ram_we = advance && v_s4 && (cmd_s4 == CMD_WRITE) && (32'(ei_s4) < DEPTH);

	cbl_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_row0 (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(ei_s4)),
		.wdata   (ed_s4),
		.re      (advance),
		.raddr_a (a_ll[AW-1:0]),
		.raddr_b (a_hl[AW-1:0]),
		.rdata_a (rd_ll),
		.rdata_b (rd_hl)
	);

	cbl_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_row1 (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(ei_s4)),
		.wdata   (ed_s4),
		.re      (advance),
		.raddr_a (a_lh[AW-1:0]),
		.raddr_b (a_hh[AW-1:0]),
		.rdata_a (rd_lh),
		.rdata_b (rd_hh)
	);

	assign ll_s5 = rd_ll;
	assign hl_s5 = rd_hl;
	assign lh_s5 = rd_lh;
	assign hh_s5 = rd_hh;

	// s5 -> s6: exact horizontal blend; s6 -> out: vertical blend, round half up
	logic [16:0]            xw0, yw0;
	logic [NCHAN-1:0][32:0] top_c, bot_c;
	logic [NCHAN-1:0][48:0] vert_c;

	assign xw0 = 17'h10000 - 17'(xf_s5);
	assign yw0 = 17'h10000 - 17'(yf_s6);

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			top_c[c] = 33'(ll_s5[c*CHAN_W +: CHAN_W]) * 33'(xw0)
				+ 33'(hl_s5[c*CHAN_W +: CHAN_W]) * 33'(xf_s5);
			bot_c[c] = 33'(lh_s5[c*CHAN_W +: CHAN_W]) * 33'(xw0)
				+ 33'(hh_s5[c*CHAN_W +: CHAN_W]) * 33'(xf_s5);
			vert_c[c] = 49'(top_s6[c]) * 49'(yw0) + 49'(bot_s6[c]) * 49'(yf_s6)
				+ 49'h0_8000_0000;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int c = 0; c < NCHAN; c++) begin
				top_s6[c] <= top_c[c][31:0];
				bot_s6[c] <= bot_c[c][31:0];
				out_q[c]  <= vert_c[c][47:32];
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.out_red   = out_q[0];
	assign rsp.out_green = out_q[1];
	assign rsp.out_blue  = out_q[2];
	assign rsp.out_alpha = out_q[3];

	// a stall freezes every stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6}))
		else $error("pipeline moved during stall");

	// no table write while a stall is in effect
	a_no_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> advance)
		else $error("table written during stall");

	// a lookup in s6 becomes a response on the next move
	a_s6_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s6) |=> out_valid_q)
		else $error("lookup lost between s6 and output");

	// neighbor indices stay inside the table
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && cmd_s4 != CMD_WRITE |-> (32'(x1_s4) <= 32'(w_lim))
			&& (32'(y1_s4) <= 32'(h_lim)))
		else $error("neighbor index beyond table edge");

endmodule

@@ src/cbl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbl_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cbl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
